[hdl/bmpdec_pkg.sv]
package bmpdec_pkg;

  localparam int ADDR_W = 21;
  localparam int ARGB_W = 32;

  localparam logic [7:0]  MAGIC_B     = 8'h42;
  localparam logic [7:0]  MAGIC_M     = 8'h4D;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
  localparam logic [15:0] DEPTH_24    = 16'd24;
  localparam logic [15:0] DEPTH_32    = 16'd32;
  localparam logic [31:0] COMP_RGB       = 32'd0;
  localparam logic [31:0] COMP_BITFIELDS = 32'd3;
  localparam logic [31:0] HDR_BYTES   = 32'd54;

  typedef enum logic [2:0] {
    KIND_PIXEL       = 3'd0,
    KIND_NOT_BMP     = 3'd1,
    KIND_TRUNC_HDR   = 3'd2,
    KIND_COMPRESSED  = 3'd3,
    KIND_BAD_DEPTH   = 3'd4,
    KIND_BAD_SIZE    = 3'd5,
    KIND_BAD_OFFSET  = 3'd6,
    KIND_TRUNC_DATA  = 3'd7
  } kind_t;

  typedef struct packed {
    logic              emit;
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [ARGB_W-1:0] argb;
    logic              done;
  } result_t;

endpackage

[hdl/bmpdec_core.sv]
module bmpdec_core
  import bmpdec_pkg::*;
#(
  parameter int MAX_WIDTH  = 1280,
  parameter int MAX_HEIGHT = 1092
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output result_t    res
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = WW + HW;
  localparam int SW = (PW + 1 > ADDR_W) ? PW + 1 : ADDR_W;

  localparam logic [31:0] IDX_MAGIC_M = 32'd1;
  localparam logic [31:0] IDX_OFFSET  = 32'd13;
  localparam logic [31:0] IDX_WIDTH   = 32'd21;
  localparam logic [31:0] IDX_HEIGHT  = 32'd25;
  localparam logic [31:0] IDX_DEPTH   = 32'd29;
  localparam logic [31:0] IDX_COMP    = 32'd33;
  localparam logic [31:0] IDX_HDR_END = 32'd53;

  typedef enum logic [2:0] {
    PH_HDR        = 3'd0,
    PH_PEND_COMP  = 3'd1,
    PH_PEND_DEPTH = 3'd2,
    PH_PEND_SIZE  = 3'd3,
    PH_SKIP       = 3'd4,
    PH_DATA       = 3'd5,
    PH_PAD        = 3'd6,
    PH_IDLE       = 3'd7
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [31:0]     byte_count_r, byte_count_nxt;
  logic [31:0]     header_shift_r, header_shift_nxt;
  logic            magic_ok_r, magic_ok_nxt;
  logic [31:0]     data_start_r, data_start_nxt;
  logic [WW-1:0]   width_r, width_nxt;
  logic [HW-1:0]   height_r, height_nxt;
  logic            bottom_up_r, bottom_up_nxt;
  logic            four_bpp_r, four_bpp_nxt;
  logic [1:0]      byte_in_pixel_r, byte_in_pixel_nxt;
  logic [15:0]     bg_hold_r, bg_hold_nxt;
  logic [WW-1:0]   column_r, column_nxt;
  logic [HW-1:0]   file_row_r, file_row_nxt;
  logic [1:0]      pad_left_r, pad_left_nxt;

  logic [31:0]     shift_new;
  logic [31:0]     height_mag;
  logic [HW-1:0]   dst_y;
  logic [PW-1:0]   prod;
  logic [PW:0]     sum;
  logic [SW-1:0]   sum_ext;
  logic            col_last;
  logic            row_last;

  assign shift_new = {file_byte, header_shift_r[31:8]};
  assign height_mag = shift_new[31] ? (~shift_new + 32'd1) : shift_new;

  // display row: flip file rows for bottom-up images
  assign dst_y   = bottom_up_r ? (height_r - HW'(1) - file_row_r) : file_row_r;
  assign prod    = PW'(dst_y) * PW'(width_r);
  assign sum     = {1'b0, prod} + (PW + 1)'(column_r);
  assign sum_ext = SW'(sum);
  assign col_last = (({1'b0, column_r} + (WW + 1)'(1)) >= {1'b0, width_r});
  assign row_last = (({1'b0, file_row_r} + (HW + 1)'(1)) >= {1'b0, height_r});

  always_comb begin
    phase_nxt         = phase_r;
    byte_count_nxt    = byte_count_r + 32'd1;
    header_shift_nxt  = header_shift_r;
    magic_ok_nxt      = magic_ok_r;
    data_start_nxt    = data_start_r;
    width_nxt         = width_r;
    height_nxt        = height_r;
    bottom_up_nxt     = bottom_up_r;
    four_bpp_nxt      = four_bpp_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    bg_hold_nxt       = bg_hold_r;
    column_nxt        = column_r;
    file_row_nxt      = file_row_r;
    pad_left_nxt      = pad_left_r;
    res               = '0;
    res.kind          = KIND_PIXEL;

    case (phase_r)
      PH_HDR, PH_PEND_COMP, PH_PEND_DEPTH, PH_PEND_SIZE: begin
        header_shift_nxt = shift_new;
        if (byte_count_r == 32'd0) begin
          magic_ok_nxt = (file_byte == MAGIC_B);
        end else if (byte_count_r == IDX_MAGIC_M) begin
          if (!magic_ok_r || file_byte != MAGIC_M) begin
            res.emit  = 1'b1;
            res.kind  = KIND_NOT_BMP;
            phase_nxt = PH_IDLE;
          end
        end else if (byte_count_r == IDX_OFFSET) begin
          data_start_nxt = shift_new;
        end else if (byte_count_r == IDX_WIDTH) begin
          width_nxt = shift_new[WW-1:0];
          if (shift_new == 32'd0 || shift_new > 32'(MAX_WIDTH)) phase_nxt = PH_PEND_SIZE;
        end else if (byte_count_r == IDX_HEIGHT) begin
          bottom_up_nxt = !shift_new[31];
          height_nxt    = height_mag[HW-1:0];
          if (height_mag == 32'd0 || height_mag > 32'(MAX_HEIGHT)) phase_nxt = PH_PEND_SIZE;
        end else if (byte_count_r == IDX_DEPTH) begin
          if (shift_new[31:16] == DEPTH_24) four_bpp_nxt = 1'b0;
          else if (shift_new[31:16] == DEPTH_32) four_bpp_nxt = 1'b1;
          else phase_nxt = PH_PEND_DEPTH;
        end else if (byte_count_r == IDX_COMP) begin
          if (shift_new != COMP_RGB && shift_new != COMP_BITFIELDS) phase_nxt = PH_PEND_COMP;
        end else if (byte_count_r == IDX_HDR_END) begin
          case (phase_r)
            PH_PEND_COMP: begin
              res.emit = 1'b1; res.kind = KIND_COMPRESSED; phase_nxt = PH_IDLE;
            end
            PH_PEND_DEPTH: begin
              res.emit = 1'b1; res.kind = KIND_BAD_DEPTH; phase_nxt = PH_IDLE;
            end
            PH_PEND_SIZE: begin
              res.emit = 1'b1; res.kind = KIND_BAD_SIZE; phase_nxt = PH_IDLE;
            end
            default: begin
              if (data_start_r < HDR_BYTES) begin
                res.emit = 1'b1; res.kind = KIND_BAD_OFFSET; phase_nxt = PH_IDLE;
              end else begin
                column_nxt        = '0;
                file_row_nxt      = '0;
                byte_in_pixel_nxt = 2'd0;
                pad_left_nxt      = 2'd0;
                phase_nxt         = (data_start_r == HDR_BYTES) ? PH_DATA : PH_SKIP;
              end
            end
          endcase
        end
      end
      PH_SKIP: begin
        if (byte_count_nxt == data_start_r) phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        case (byte_in_pixel_r)
          2'd0: begin
            bg_hold_nxt       = {8'h00, file_byte};
            byte_in_pixel_nxt = 2'd1;
          end
          2'd1: begin
            bg_hold_nxt       = {file_byte, bg_hold_r[7:0]};
            byte_in_pixel_nxt = 2'd2;
          end
          2'd2: begin
            res.emit          = 1'b1;
            res.kind          = KIND_PIXEL;
            res.addr          = sum_ext[ADDR_W-1:0];
            res.argb          = ALPHA_OPAQUE | {8'h00, file_byte, bg_hold_r};
            byte_in_pixel_nxt = four_bpp_r ? 2'd3 : 2'd0;
            if (col_last) begin
              if (row_last) begin
                res.done  = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                column_nxt   = '0;
                file_row_nxt = file_row_r + HW'(1);
                // 24bpp rows pad to four bytes: width mod 4 bytes of padding
                pad_left_nxt = four_bpp_r ? 2'd0 : width_r[1:0];
                if (!four_bpp_r && width_r[1:0] != 2'd0) phase_nxt = PH_PAD;
              end
            end else begin
              column_nxt = column_r + WW'(1);
            end
          end
          default: begin
            byte_in_pixel_nxt = 2'd0;
          end
        endcase
      end
      PH_PAD: begin
        pad_left_nxt = pad_left_r - 2'd1;
        if (pad_left_r == 2'd1) phase_nxt = PH_DATA;
      end
      default: begin
      end
    endcase

    if (end_of_file) begin
      if (phase_nxt == PH_HDR || phase_nxt == PH_PEND_COMP ||
          phase_nxt == PH_PEND_DEPTH || phase_nxt == PH_PEND_SIZE) begin
        res      = '0;
        res.emit = 1'b1;
        res.kind = (byte_count_r < IDX_OFFSET) ? KIND_NOT_BMP : KIND_TRUNC_HDR;
      end else if (phase_nxt == PH_SKIP || phase_nxt == PH_DATA || phase_nxt == PH_PAD) begin
        res      = '0;
        res.emit = 1'b1;
        res.kind = KIND_TRUNC_DATA;
      end
      // restart for the next file
      phase_nxt         = PH_HDR;
      byte_count_nxt    = '0;
      header_shift_nxt  = '0;
      magic_ok_nxt      = 1'b0;
      data_start_nxt    = '0;
      width_nxt         = '0;
      height_nxt        = '0;
      bottom_up_nxt     = 1'b1;
      four_bpp_nxt      = 1'b0;
      byte_in_pixel_nxt = 2'd0;
      bg_hold_nxt       = '0;
      column_nxt        = '0;
      file_row_nxt      = '0;
      pad_left_nxt      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HDR;
      byte_count_r    <= '0;
      header_shift_r  <= '0;
      magic_ok_r      <= 1'b0;
      data_start_r    <= '0;
      width_r         <= '0;
      height_r        <= '0;
      bottom_up_r     <= 1'b1;
      four_bpp_r      <= 1'b0;
      byte_in_pixel_r <= 2'd0;
      bg_hold_r       <= '0;
      column_r        <= '0;
      file_row_r      <= '0;
      pad_left_r      <= 2'd0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      byte_count_r    <= byte_count_nxt;
      header_shift_r  <= header_shift_nxt;
      magic_ok_r      <= magic_ok_nxt;
      data_start_r    <= data_start_nxt;
      width_r         <= width_nxt;
      height_r        <= height_nxt;
      bottom_up_r     <= bottom_up_nxt;
      four_bpp_r      <= four_bpp_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      bg_hold_r       <= bg_hold_nxt;
      column_r        <= column_nxt;
      file_row_r      <= file_row_nxt;
      pad_left_r      <= pad_left_nxt;
    end
  end

endmodule

[hdl/bmp_stream_to_argb_decoder.sv]
// BMP byte-stream decoder. Feed the bytes of a BMP file in order, one item per
// cycle, with in_tlast on the final byte; the parser restarts after that byte.
// Uncompressed (or bitfields) 24- and 32-bpp images up to MAX_WIDTH x
// MAX_HEIGHT are decoded: each pixel leaves on its red byte as opaque ARGB
// with its display address (row * width + column, rows flipped for bottom-up
// files), out_tlast marks the last pixel, and out_tuser carries the result
// kind (0 pixel, 1 not BMP, 2 truncated header, 3 compressed, 4 bad depth,
// 5 bad size, 6 data offset below 54, 7 truncated data). Bytes that yield no
// result (headers, row padding, skipped bytes) produce nothing. Throughput is
// one byte per cycle while out_tready does not hold the output back; each byte
// waits in the input register, and the per-byte parser update then writes its
// result into the result register.
module bmp_stream_to_argb_decoder
  import bmpdec_pkg::*;
#(
  parameter int MAX_WIDTH  = 1280,
  parameter int MAX_HEIGHT = 1092
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [20:0] pixel_addr, [52:21] pixel_argb, [55:53] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // image_done
);

  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;
  logic              out_vld_r;
  kind_t             kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ARGB_W-1:0] argb_r;
  logic              done_r;
  logic              out_free;
  logic              step;
  result_t           res;

  assign out_free  = !out_vld_r || out_tready;
  assign step      = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  bmpdec_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .file_byte   (in_byte_r),
    .end_of_file (in_last_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (out_free) begin
        out_vld_r <= step && res.emit;
      end
    end
  end

  // payload registers: input loads on handshake, result loads on each emitted result
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step && res.emit) begin
      kind_r <= res.kind;
      addr_r <= res.addr;
      argb_r <= res.argb;
      done_r <= res.done;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, argb_r, addr_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = done_r;

endmodule

[test/tb_bmp_stream_to_argb_decoder.sv]
module tb_bmp_stream_to_argb_decoder;
  import bmpdec_pkg::*;

  localparam int MAX_W = 1280;
  localparam int MAX_H = 1092;

  typedef enum logic [2:0] {
    ST_HDR, ST_ERR_COMP, ST_ERR_DEPTH, ST_ERR_SIZE, ST_SKIP, ST_DATA, ST_PAD, ST_IDLE
  } parse_stage_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [ARGB_W-1:0] argb;
    logic              done;
  } decoded_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] file_byte
  logic        in_tlast;   // end_of_file
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [20:0] pixel_addr, [52:21] pixel_argb, [55:53] zero
  logic [2:0]  out_tuser;  // [2:0] kind
  logic        out_tlast;  // image_done

  // parser state mirrored from the file format rules
  parse_stage_t stage;
  logic [31:0]  n_bytes;
  logic [31:0]  shift_reg;
  logic         saw_b;
  logic [31:0]  pix_offset;
  logic [31:0]  img_w;
  logic [31:0]  img_h;
  logic         flip_rows;
  logic         quad_bytes;
  logic [1:0]   pix_byte;
  logic [15:0]  bg_hold;
  logic [31:0]  col_idx;
  logic [31:0]  row_idx;
  logic [1:0]   pad_cnt;

  decoded_item_t pending_decodes[$];
  decoded_item_t head_item;
  logic [7:0]    file_bytes[$];

  int  errors;
  int  bytes_sent;
  int  files_sent;
  int  results_seen;
  int  kind_count[8];
  int  sink_hold;
  bit  src_idle;
  bit  sink_idle;

  bmp_stream_to_argb_decoder #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("[bmp_stream_to_argb_decoder] ERROR");
    $finish;
  end

  function automatic void clear_parser();
    stage      = ST_HDR;
    n_bytes    = '0;
    shift_reg  = '0;
    saw_b      = 1'b0;
    pix_offset = '0;
    img_w      = '0;
    img_h      = '0;
    flip_rows  = 1'b1;
    quad_bytes = 1'b0;
    pix_byte   = '0;
    bg_hold    = '0;
    col_idx    = '0;
    row_idx    = '0;
    pad_cnt    = '0;
  endfunction

  // Advance the parser by one file byte and queue the result it yields, if any.
  function automatic void decode_byte(logic [7:0] b, logic eof);
    decoded_item_t r;
    logic          hit;
    logic [31:0]   idx;
    logic [31:0]   mag;
    logic [31:0]   dst_y;
    logic [31:0]   lin;
    logic [31:0]   line_bytes;
    logic [31:0]   pad32;
    r   = '0;
    hit = 1'b0;
    idx = n_bytes;
    n_bytes = idx + 32'd1;
    if (stage <= ST_ERR_SIZE) begin
      shift_reg = {b, shift_reg[31:8]};
      if (idx == 0) begin
        saw_b = (b == MAGIC_B);
      end else if (idx == 1) begin
        if (!saw_b || b != MAGIC_M) begin
          hit = 1'b1; r.kind = KIND_NOT_BMP; stage = ST_IDLE;
        end
      end else if (idx == 13) begin
        pix_offset = shift_reg;
      end else if (idx == 21) begin
        img_w = shift_reg;
        if (shift_reg == 0 || shift_reg > MAX_W) stage = ST_ERR_SIZE;
      end else if (idx == 25) begin
        mag = shift_reg;
        flip_rows = 1'b1;
        if (shift_reg[31]) begin
          mag = ~shift_reg + 32'd1;
          flip_rows = 1'b0;
        end
        img_h = mag;
        if (mag == 0 || mag > MAX_H) stage = ST_ERR_SIZE;
      end else if (idx == 29) begin
        if (shift_reg[31:16] == DEPTH_24) quad_bytes = 1'b0;
        else if (shift_reg[31:16] == DEPTH_32) quad_bytes = 1'b1;
        else stage = ST_ERR_DEPTH;
      end else if (idx == 33) begin
        if (shift_reg != COMP_RGB && shift_reg != COMP_BITFIELDS) stage = ST_ERR_COMP;
      end else if (idx == 53) begin
        hit = 1'b1;
        case (stage)
          ST_ERR_COMP:  r.kind = KIND_COMPRESSED;
          ST_ERR_DEPTH: r.kind = KIND_BAD_DEPTH;
          ST_ERR_SIZE:  r.kind = KIND_BAD_SIZE;
          default: begin
            if (pix_offset < HDR_BYTES) begin
              r.kind = KIND_BAD_OFFSET;
            end else begin
              hit = 1'b0;
              col_idx = '0; row_idx = '0; pix_byte = '0; pad_cnt = '0;
            end
          end
        endcase
        if (hit) stage = ST_IDLE;
        else stage = (pix_offset == HDR_BYTES) ? ST_DATA : ST_SKIP;
      end
    end else if (stage == ST_SKIP) begin
      if (n_bytes == pix_offset) stage = ST_DATA;
    end else if (stage == ST_DATA) begin
      case (pix_byte)
        2'd0: begin bg_hold = {8'h00, b}; pix_byte = 2'd1; end
        2'd1: begin bg_hold = {b, bg_hold[7:0]}; pix_byte = 2'd2; end
        2'd2: begin
          dst_y = flip_rows ? (img_h - 32'd1 - row_idx) : row_idx;
          lin = dst_y * img_w + col_idx;
          hit = 1'b1;
          r.kind = KIND_PIXEL;
          r.addr = lin[ADDR_W-1:0];
          r.argb = ALPHA_OPAQUE | {8'h00, b, bg_hold};
          pix_byte = quad_bytes ? 2'd3 : 2'd0;
          if (col_idx + 32'd1 >= img_w) begin
            if (row_idx + 32'd1 >= img_h) begin
              r.done = 1'b1;
              stage = ST_IDLE;
            end else begin
              col_idx = '0;
              row_idx = row_idx + 32'd1;
              line_bytes = img_w * (quad_bytes ? 32'd4 : 32'd3);
              pad32 = ((line_bytes + 32'd3) & ~32'd3) - line_bytes;
              pad_cnt = pad32[1:0];
              if (pad_cnt != 0) stage = ST_PAD;
            end
          end else begin
            col_idx = col_idx + 32'd1;
          end
        end
        default: pix_byte = 2'd0;
      endcase
    end else if (stage == ST_PAD) begin
      pad_cnt = pad_cnt - 2'd1;
      if (pad_cnt == 0) stage = ST_DATA;
    end

    if (eof) begin
      if (stage <= ST_ERR_SIZE) begin
        hit = 1'b1;
        r = '0;
        r.kind = (idx < 13) ? KIND_NOT_BMP : KIND_TRUNC_HDR;
      end else if (stage == ST_SKIP || stage == ST_DATA || stage == ST_PAD) begin
        hit = 1'b1;
        r = '0;
        r.kind = KIND_TRUNC_DATA;
      end
      clear_parser();
    end
    if (hit) pending_decodes.push_back(r);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void append_noise(int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Start a new file: 14-byte file header plus 40-byte info header.
  function automatic void make_header(logic [15:0] magic, logic [31:0] offset,
                                      logic [31:0] width, logic [31:0] height,
                                      logic [15:0] depth, logic [31:0] comp);
    file_bytes.delete();
    put_le(32'(magic), 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(offset, 4);
    put_le(32'd40, 4);
    put_le(width, 4);
    put_le(height, 4);
    put_le($urandom, 2);
    put_le(32'(depth), 2);
    put_le(comp, 4);
    repeat (5) put_le($urandom, 4);
  endfunction

  function automatic void append_image(logic [31:0] offset, int w, int h,
                                       logic [15:0] depth, int tail);
    int stride;
    int gap;
    stride = (w * ((depth == DEPTH_32) ? 4 : 3) + 3) / 4 * 4;
    gap = (offset > HDR_BYTES) ? int'(offset - HDR_BYTES) : 0;
    append_noise(gap + h * stride + tail);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, eof);
    bytes_sent++;
  endtask

  // Send the first len bytes of the built file, marking the last one.
  task automatic send_file(input int len);
    if (len > file_bytes.size()) len = file_bytes.size();
    for (int i = 0; i < len; i++) send_byte(file_bytes[i], i == len - 1);
    files_sent++;
  endtask

  task automatic send_image(input int w, input int h, input logic [15:0] depth,
                            input logic [31:0] comp, input logic [31:0] offset,
                            input int tail, input int cut);
    make_header({MAGIC_M, MAGIC_B}, offset, w, h, depth, comp);
    append_image(offset, w, (h < 0) ? -h : h, depth, tail);
    send_file((cut > 0) ? cut : file_bytes.size());
  endtask

  task automatic send_header(input logic [31:0] offset, input logic [31:0] width,
                             input logic [31:0] height, input logic [15:0] depth,
                             input logic [31:0] comp, input int tail);
    make_header({MAGIC_M, MAGIC_B}, offset, width, height, depth, comp);
    append_noise(tail);
    send_file(file_bytes.size());
  endtask

  task automatic test_small_images();
    src_idle = 1'b1; sink_idle = 1'b1;
    // bottom-up with three bytes of row padding
    send_image(3, 2, DEPTH_24, COMP_RGB, HDR_BYTES, 0, 0);
  endtask

  task automatic test_header_errors();
    src_idle = 1'b1; sink_idle = 1'b0;
    make_header({MAGIC_M, 8'h41}, HDR_BYTES, 2, 2, DEPTH_24, COMP_RGB);
    send_file(2);
    make_header({8'h4E, MAGIC_B}, HDR_BYTES, 2, 2, DEPTH_24, COMP_RGB);
    send_file(3);
    // compression outranks depth, depth outranks size
    send_header(HDR_BYTES, 0, 0, 16'd8, 32'd2, 0);
    send_header(HDR_BYTES, 0, 2, 16'd8, COMP_RGB, 0);
    send_header(HDR_BYTES, 2, -(MAX_H + 1), DEPTH_24, COMP_RGB, 0);
    send_header(HDR_BYTES - 1, 2, 2, DEPTH_24, COMP_RGB, 0);
  endtask

  task automatic test_truncation();
    src_idle = 1'b0; sink_idle = 1'b1;
    send_image(2, 2, DEPTH_24, COMP_RGB, HDR_BYTES, 0, 13);
    send_image(2, 2, DEPTH_24, COMP_RGB, HDR_BYTES, 0, 14);
    // end marker on a red byte replaces the pixel
    send_image(2, 2, DEPTH_24, COMP_RGB, HDR_BYTES, 0, 57);
  endtask

  task automatic test_size_extremes();
    src_idle = 1'b0; sink_idle = 1'b0;
    // full-size frame, cut short: the first row lands at the top addresses
    send_header(HDR_BYTES, MAX_W, MAX_H, DEPTH_24, COMP_RGB, 7);
  endtask

  task automatic test_backpressure();
    src_idle = 1'b0; sink_idle = 1'b0;
    sink_hold = 40;
    // top-down 32bpp behind a skipped gap
    send_image(2, -2, DEPTH_32, COMP_BITFIELDS, HDR_BYTES + 2, 0, 0);
  endtask

  task automatic test_random_files();
    int          pick;
    int          w;
    int          h;
    int          cut;
    logic [15:0] magic;
    logic [15:0] depth;
    logic [31:0] width;
    logic [31:0] height;
    logic [31:0] offset;
    logic [31:0] comp;
    do begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      w = $urandom_range(1, 7);
      h = $urandom_range(1, 4);
      magic  = {MAGIC_M, MAGIC_B};
      depth  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      width  = w;
      height = $urandom_range(0, 1) ? -h : h;
      offset = ($urandom_range(0, 3) == 0) ? HDR_BYTES + $urandom_range(1, 6) : HDR_BYTES;
      comp   = $urandom_range(0, 1) ? COMP_BITFIELDS : COMP_RGB;
      if (pick == 9) begin
        // noise, sometimes behind a valid magic
        file_bytes.delete();
        if ($urandom_range(0, 1)) put_le({16'h0000, MAGIC_M, MAGIC_B}, 2);
        append_noise($urandom_range(1, 70));
        send_file(file_bytes.size());
      end else if (pick == 8) begin
        case ($urandom_range(0, 5))
          0: comp = $urandom;
          1: depth = 16'($urandom_range(0, 40));
          2: width = $urandom;
          3: height = $urandom_range(0, 1) ? $urandom : 32'h8000_0000;
          4: offset = $urandom_range(0, 53);
          default: magic[4'($urandom_range(0, 15))] ^= 1'b1;
        endcase
        make_header(magic, offset, width, height, depth, comp);
        append_noise($urandom_range(0, 8));
        send_file(file_bytes.size());
      end else begin
        make_header(magic, offset, width, height, depth, comp);
        append_image(offset, w, h, depth, $urandom_range(0, 3));
        cut = file_bytes.size();
        if (pick == 7) cut = $urandom_range(1, cut);
        send_file(cut);
      end
    end while (bytes_sent < 540);
  endtask

  // Receiver: random stall per result, or a long hold when one is requested.
  initial begin : result_sink
    int gap;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else begin
        gap = sink_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      kind_count[out_tuser]++;
      if (pending_decodes.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, got kind %0d addr %h argb %h",
                   $time, out_tuser, out_tdata[20:0], out_tdata[52:21]);
      end else begin
        head_item = pending_decodes.pop_front();
        if (out_tuser !== head_item.kind)
          flag_mismatch("kind", 32'(head_item.kind), 32'(out_tuser));
        if (out_tdata[20:0] !== head_item.addr)
          flag_mismatch("pixel_addr", 32'(head_item.addr), 32'(out_tdata[20:0]));
        if (out_tdata[52:21] !== head_item.argb)
          flag_mismatch("pixel_argb", head_item.argb, out_tdata[52:21]);
        if (out_tlast !== head_item.done)
          flag_mismatch("image_done", 32'(head_item.done), 32'(out_tlast));
        if (out_tdata[55:53] !== 3'b000)
          flag_mismatch("tdata fill", 32'd0, 32'(out_tdata[55:53]));
      end
    end
  end

  initial begin
    errors = 0;
    bytes_sent = 0;
    files_sent = 0;
    results_seen = 0;
    sink_hold = 0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    foreach (kind_count[k]) kind_count[k] = 0;
    clear_parser();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_small_images();
    test_header_errors();
    test_truncation();
    test_size_extremes();
    test_backpressure();
    test_random_files();
    in_tvalid <= 1'b0;

    for (int n = 0; n < 1000 && pending_decodes.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_decodes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived, expected kind %0d first",
               $time, pending_decodes.size(), pending_decodes[0].kind);
    end

    $display("Sent %0d files (%0d bytes): padded, skipped, top-down and bottom-up images,",
             files_sent, bytes_sent);
    $display("header faults and cut files; %0d results, per kind %0d %0d %0d %0d %0d %0d %0d %0d",
             results_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
    if (errors == 0) begin
      $display("[bmp_stream_to_argb_decoder] OK");
    end else begin
      $display("[bmp_stream_to_argb_decoder] ERROR");
    end
    $finish;
  end

endmodule
